@@ rtl/iwtf_pkg.sv @@
// Shared types, constants and controller commands for the waveform trap force block.
`default_nettype none

package iwtf_pkg;

  // Default waveform table depth.
  localparam int TABLE_DEPTH_DEF = 1024;

  // Field widths.
  localparam int CNT_W      = 11;
  localparam int PHASE_W    = 32;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 32;
  localparam int POS_W      = 32;
  localparam int LOAD_IDX_W = 10;

  // Stream and register port widths.
  localparam int IN_DATA_W  = 160;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 112;
  localparam int OUT_USER_W = 3;
  localparam int ADDR_W     = 4;
  localparam int REG_W      = 32;

  localparam logic [CNT_W-1:0] POINT_COUNT_RST = 11'd1024;

  localparam logic signed [POS_W-1:0] FORCE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [POS_W-1:0] FORCE_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REG_POINT_COUNT = 2'd0,
    REG_Q_COEF      = 2'd1,
    REG_A_COEF      = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_STEP  = 2'd1,
    OP_FORCE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // Operand selection of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_PHASE,
    MUL_MIX,
    MUL_T,
    MUL_LO,
    MUL_HI
  } mul_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PH_MUL,
    S_RD_LO,
    S_RD_HI,
    S_MIX_MUL,
    S_MIX_END,
    S_T_MUL,
    S_T_CAP,
    S_COEF,
    S_F_LO,
    S_F_HI,
    S_F_END,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     take;
    logic     load_wr;
    logic     phase_add;
    mul_sel_t mul_sel;
    logic     rd_lo;
    logic     rd_hi;
    logic     mix_end;
    logic     t_cap;
    logic     coef_ld;
    logic     lo_cap;
    logic     f_end;
    logic     out_ld;
    axis_t    axis;
  } cmd_t;

endpackage

`default_nettype wire

@@ rtl/iwtf_ctrl.sv @@
// Controller state machine that sequences loads, time steps and force queries.
`default_nettype none

module iwtf_ctrl import iwtf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  input  op_t  op,
  input  logic m_tready,
  output logic s_tready,
  output logic m_tvalid,
  output cmd_t cmd
);

  state_t state, state_next;
  axis_t  axis, axis_next;
  logic   m_tvalid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      axis     <= AXIS_X;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      axis     <= axis_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    axis_next  = axis;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          case (op)
            OP_STEP:  state_next = S_PH_MUL;
            OP_FORCE: state_next = S_T_MUL;
            default:  state_next = S_OUT;
          endcase
        end
      end
      S_PH_MUL:  state_next = S_RD_LO;
      S_RD_LO:   state_next = S_RD_HI;
      S_RD_HI:   state_next = S_MIX_MUL;
      S_MIX_MUL: state_next = S_MIX_END;
      S_MIX_END: state_next = S_OUT;
      S_T_MUL:   state_next = S_T_CAP;
      S_T_CAP: begin
        state_next = S_COEF;
        axis_next  = AXIS_X;
      end
      S_COEF:    state_next = S_F_LO;
      S_F_LO:    state_next = S_F_HI;
      S_F_HI:    state_next = S_F_END;
      S_F_END: begin
        case (axis)
          AXIS_X: begin
            state_next = S_COEF;
            axis_next  = AXIS_Y;
          end
          AXIS_Y: begin
            state_next = S_COEF;
            axis_next  = AXIS_Z;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd         = '0;
    cmd.mul_sel = MUL_NONE;
    cmd.axis    = axis;
    s_tready    = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready      = 1'b1;
        cmd.take      = s_tvalid;
        cmd.load_wr   = s_tvalid && (op == OP_LOAD);
        cmd.phase_add = s_tvalid && (op == OP_STEP);
      end
      S_PH_MUL:  cmd.mul_sel = MUL_PHASE;
      S_RD_LO:   cmd.rd_lo   = 1'b1;
      S_RD_HI:   cmd.rd_hi   = 1'b1;
      S_MIX_MUL: cmd.mul_sel = MUL_MIX;
      S_MIX_END: cmd.mix_end = 1'b1;
      S_T_MUL:   cmd.mul_sel = MUL_T;
      S_T_CAP:   cmd.t_cap   = 1'b1;
      S_COEF:    cmd.coef_ld = 1'b1;
      S_F_LO:    cmd.mul_sel = MUL_LO;
      S_F_HI: begin
        cmd.mul_sel = MUL_HI;
        cmd.lo_cap  = 1'b1;
      end
      S_F_END:   cmd.f_end   = 1'b1;
      S_OUT:     cmd.out_ld  = !m_tvalid || m_tready;
      default:   cmd.out_ld  = 1'b0;
    endcase
  end

  always_comb begin
    if (cmd.out_ld) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end else begin
      m_tvalid_next = m_tvalid;
    end
  end

endmodule

`default_nettype wire

@@ rtl/iwtf_dp.sv @@
// Datapath: waveform memory, phase accumulator, shared multiplier and force saturation.
`default_nettype none

module iwtf_dp import iwtf_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  cmd_t                          cmd,
  input  logic [IN_DATA_W-1:0]          s_tdata,
  input  logic [IN_USER_W-1:0]          s_tuser,
  input  logic [CNT_W-1:0]              point_count,
  input  logic signed [COEF_W-1:0]      q_coef,
  input  logic signed [COEF_W-1:0]      a_coef,
  output logic [OUT_DATA_W-1:0]         m_tdata,
  output logic [OUT_USER_W-1:0]         m_tuser
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  // Unpacked input fields.
  logic [LOAD_IDX_W-1:0]      in_index;
  logic signed [SAMPLE_W-1:0] in_value;
  logic [PHASE_W-1:0]         in_step;
  logic signed [POS_W-1:0]    in_pos_x, in_pos_y, in_pos_z;

  assign in_index = s_tdata[9:0];
  assign in_value = s_tdata[25:10];
  assign in_step  = s_tdata[57:26];
  assign in_pos_x = s_tdata[89:58];
  assign in_pos_y = s_tdata[121:90];
  assign in_pos_z = s_tdata[153:122];

  // Architectural state.
  logic [PHASE_W-1:0]         phase_acc;
  logic signed [SAMPLE_W-1:0] held_voltage;

  // Working registers.
  logic [IN_USER_W-1:0]       kind;
  logic signed [POS_W-1:0]    pos_x, pos_y, pos_z;
  logic [CNT_W-1:0]           n_eff, n_eff_next;
  logic signed [52:0]         prod;
  logic [CNT_W-1:0]           i2;
  logic signed [SAMPLE_W-1:0] v1, rdata;
  logic signed [33:0]         t;
  logic signed [34:0]         coef, coef_next;
  logic signed [31:0]         plo;
  logic signed [POS_W-1:0]    fx, fy, fz;
  logic                       clip;

  // Output register.
  logic [IN_USER_W-1:0]       o_kind;
  logic signed [SAMPLE_W-1:0] o_volt;
  logic signed [POS_W-1:0]    o_fx, o_fy, o_fz;
  logic                       o_clip;

  logic signed [SAMPLE_W-1:0] wave_mem [TABLE_DEPTH];

  logic                       load_ok;
  logic [IDX_W-1:0]           wr_addr, rd_addr;
  logic                       rd_en;
  logic [CNT_W-1:0]           i1;
  logic [CNT_W:0]             i1_inc;
  logic signed [32:0]         ma;
  logic signed [19:0]         mb;
  logic signed [16:0]         mix_diff;
  logic signed [33:0]         mix;
  logic signed [POS_W-1:0]    pos_sel;
  logic signed [34:0]         t_ext, a_ext;
  logic signed [51:0]         f_sum;
  logic signed [POS_W-1:0]    f_res;
  logic                       f_sat;

  // Effective point count: zero counts as one, clamped to the table depth.
  always_comb begin
    if (point_count == '0) begin
      n_eff_next = CNT_W'(1);
    end else if (32'(point_count) > TABLE_DEPTH) begin
      n_eff_next = CNT_W'(TABLE_DEPTH);
    end else begin
      n_eff_next = point_count;
    end
  end

  assign load_ok = 32'(in_index) < TABLE_DEPTH;
  assign wr_addr = IDX_W'(in_index);

  // The phase product holds the table position: index from bit 32 up, fraction below.
  assign i1      = prod[42:32];
  assign i1_inc  = {1'b0, i1} + (CNT_W+1)'(1);
  assign rd_en   = cmd.rd_lo || cmd.rd_hi;
  assign rd_addr = cmd.rd_lo ? IDX_W'(i1) : IDX_W'(i2);

  always_ff @(posedge clk) begin
    if (cmd.load_wr && load_ok) begin
      wave_mem[wr_addr] <= in_value;
    end
    if (rd_en) begin
      rdata <= wave_mem[rd_addr];
    end
  end

  always_comb begin
    case (cmd.axis)
      AXIS_X:  pos_sel = pos_x;
      AXIS_Y:  pos_sel = pos_y;
      default: pos_sel = pos_z;
    endcase
  end

  assign mix_diff = {rdata[15], rdata} - {v1[15], v1};

  // Shared multiplier operand selection.
  always_comb begin
    case (cmd.mul_sel)
      MUL_PHASE: begin
        ma = {1'b0, phase_acc};
        mb = {9'b0, n_eff};
      end
      MUL_MIX: begin
        ma = {{16{mix_diff[16]}}, mix_diff};
        mb = {4'b0, prod[31:16]};
      end
      MUL_T: begin
        ma = {q_coef[31], q_coef};
        mb = {{4{held_voltage[15]}}, held_voltage};
      end
      MUL_LO: begin
        ma = {pos_sel[31], pos_sel};
        mb = {4'b0, coef[15:0]};
      end
      MUL_HI: begin
        ma = {pos_sel[31], pos_sel};
        mb = {coef[34], coef[34:16]};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign t_ext = {t[33], t};
  assign a_ext = {{3{a_coef[31]}}, a_coef};

  always_comb begin
    case (cmd.axis)
      AXIS_X:  coef_next = t_ext - a_ext;
      AXIS_Y:  coef_next = 35'sd0 - t_ext - a_ext;
      default: coef_next = a_ext <<< 1;
    endcase
  end

  assign mix = {{2{v1[15]}}, v1, 16'b0} + prod[33:0];

  // High partial product plus the floored low partial product, then saturation.
  assign f_sum = {prod[50], prod[50:0]} + {{20{plo[31]}}, plo};

  always_comb begin
    if ((f_sum[51:31] == '0) || (f_sum[51:31] == '1)) begin
      f_res = f_sum[31:0];
      f_sat = 1'b0;
    end else begin
      f_res = f_sum[51] ? FORCE_MIN : FORCE_MAX;
      f_sat = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      held_voltage <= '0;
    end else begin
      if (cmd.phase_add) begin
        phase_acc <= phase_acc + in_step;
      end
      if (cmd.mix_end) begin
        held_voltage <= mix[31:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    n_eff <= n_eff_next;
    if (cmd.take) begin
      kind  <= s_tuser;
      pos_x <= in_pos_x;
      pos_y <= in_pos_y;
      pos_z <= in_pos_z;
      fx    <= '0;
      fy    <= '0;
      fz    <= '0;
      clip  <= 1'b0;
    end
    if (cmd.mul_sel != MUL_NONE) begin
      prod <= ma * mb;
    end
    if (cmd.rd_lo) begin
      i2 <= (i1_inc >= {1'b0, n_eff}) ? '0 : i1_inc[CNT_W-1:0];
    end
    if (cmd.rd_hi) begin
      v1 <= rdata;
    end
    if (cmd.t_cap) begin
      t <= prod[47:14];
    end
    if (cmd.coef_ld) begin
      coef <= coef_next;
    end
    if (cmd.lo_cap) begin
      plo <= prod[47:16];
    end
    if (cmd.f_end) begin
      case (cmd.axis)
        AXIS_X:  fx <= f_res;
        AXIS_Y:  fy <= f_res;
        default: fz <= f_res;
      endcase
      clip <= clip | f_sat;
    end
    if (cmd.out_ld) begin
      o_kind <= kind;
      o_volt <= held_voltage;
      o_fx   <= fx;
      o_fy   <= fy;
      o_fz   <= fz;
      o_clip <= clip;
    end
  end

  assign m_tdata = {o_fz, o_fy, o_fx, o_volt};
  assign m_tuser = {o_clip, o_kind};

endmodule

`default_nettype wire

@@ rtl/interpolated_waveform_trap_force_core.sv @@
// Top level of the interpolated waveform trap force block: channels, registers and checks.
//
// Usage: requests arrive on the s_ stream. s_tuser carries the opcode: load writes one
// waveform table entry, step advances the 32-bit phase and re-interpolates the held
// potential, force multiplies the position by the Mathieu coefficients. Every request
// yields exactly one result on the m_ stream, with the opcode echoed in m_tuser.
// A load goes from the accepting edge straight to the output state. A step forms the
// phase product, reads two table entries and forms the mix product; a force query forms
// one product for the q term, then per axis loads the coefficient and forms two partial
// products. The output register is then loaded. A request is taken only while the
// controller is idle, which it reaches in the cycle after the output load. These
// sequences are set by the single shared 33x20 multiplier and the single read port
// of the waveform memory.
// The output register decouples the two sides: the next request is accepted while a
// finished result still waits; only a second result stalls until the first is taken.
// Reset (synchronous, active high) clears the phase, the held potential and all
// control state, and restores point_count to 1024 with both coefficients at zero.
// The waveform memory is not cleared; entries must be loaded before a step reads them.
// Write configuration over the register port only with no request in flight; unenforced.
`default_nettype none

module interpolated_waveform_trap_force_core import iwtf_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // Request stream.
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: table_index[9:0], table_value[25:10], phase_step[57:26],
  //          pos_x[89:58], pos_y[121:90], pos_z[153:122], zero fill above
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: opcode[1:0]
  input  logic [IN_USER_W-1:0]  s_tuser,
  // Result stream.
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: voltage_now[15:0], force_x[47:16], force_y[79:48], force_z[111:80]
  output logic [OUT_DATA_W-1:0] m_tdata,
  // m_tuser: result_kind[1:0], clipped[2]
  output logic [OUT_USER_W-1:0] m_tuser,
  // Register port.
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [REG_W-1:0]      pwdata,
  output logic [REG_W-1:0]      prdata,
  output logic                  pready
);

  logic [CNT_W-1:0]         point_count;
  logic signed [COEF_W-1:0] q_coef;
  logic signed [COEF_W-1:0] a_coef;
  logic                     reg_wr;
  reg_idx_t                 reg_idx;
  cmd_t                     cmd;

  assign pready  = 1'b1;
  assign reg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[3:2]);

  // Registers at 0, 4 and 8, decoded from paddr[3:2]; byte addresses 12 to 15 are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= POINT_COUNT_RST;
      q_coef      <= '0;
      a_coef      <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_POINT_COUNT: point_count <= pwdata[CNT_W-1:0];
        REG_Q_COEF:      q_coef      <= pwdata;
        REG_A_COEF:      a_coef      <= pwdata;
        default:         point_count <= point_count;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POINT_COUNT: prdata = {{(REG_W-CNT_W){1'b0}}, point_count};
      REG_Q_COEF:      prdata = q_coef;
      REG_A_COEF:      prdata = a_coef;
      default:         prdata = '0;
    endcase
  end

  // The controller sees only the handshake and the opcode; the datapath does the math.
  iwtf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .op       (op_t'(s_tuser)),
    .m_tready (m_tready),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .cmd      (cmd)
  );

  iwtf_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .point_count (point_count),
    .q_coef      (q_coef),
    .a_coef      (a_coef),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

`ifndef SYNTHESIS
  // Once a request is taken, the block is busy for at least the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("request accepted while previous request still in flight");

  // Only force results carry force values or the saturation flag.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (m_tuser[1:0] != OP_FORCE)) |-> ((m_tdata[111:16] == '0) && !m_tuser[2]))
    else $error("non-force result carries force data");

  // A saturation flag implies at least one component sits on a rail.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[2]) |->
      ((m_tdata[47:16] == FORCE_MAX) || (m_tdata[47:16] == FORCE_MIN) ||
       (m_tdata[79:48] == FORCE_MAX) || (m_tdata[79:48] == FORCE_MIN) ||
       (m_tdata[111:80] == FORCE_MAX) || (m_tdata[111:80] == FORCE_MIN)))
    else $error("clip flag set without a saturated component");
`endif

endmodule

`default_nettype wire

@@ verif/interpolated_waveform_trap_force_core_tb.sv @@
// Self-checking testbench for the interpolated waveform trap force block.
`default_nettype none

module interpolated_waveform_trap_force_core_tb;
  import iwtf_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Opcode 3 is not part of op_t; the block must echo it and change nothing.
  localparam logic [1:0] OP_NOP = 2'd3;

  // Payload bits that carry fields; the bits above them stay zero.
  localparam int PAYLOAD_W = 154;

  // The slowest request is a force query; the drain allows for
  // that plus a full output register and some margin.
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int REQUESTS_PER_SETTING = 104;

  localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
  localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

  // One result as the block should present it.
  typedef struct {
    logic [1:0]         kind;
    logic signed [15:0] volt;
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic signed [31:0] fz;
    logic               clip;
  } trap_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [IN_USER_W-1:0]  s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [ADDR_W-1:0]     paddr = '0;
  logic [REG_W-1:0]      pwdata = '0;
  logic [REG_W-1:0]      prdata;
  logic                  pready;

  interpolated_waveform_trap_force_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Mirror of the block's state and registers, advanced once per accepted request.
  logic [CNT_W-1:0]          cfg_points = POINT_COUNT_RST;
  logic signed [COEF_W-1:0]  cfg_q = '0;
  logic signed [COEF_W-1:0]  cfg_a = '0;
  logic [PHASE_W-1:0]        phase_acc = '0;
  logic signed [SAMPLE_W-1:0] held_volt = '0;
  logic signed [SAMPLE_W-1:0] wave_mirror [TABLE_DEPTH_DEF];
  bit                        entry_loaded [TABLE_DEPTH_DEF];

  trap_result_t pending_results[$];

  int  errors = 0;
  int  cycles = 0;
  int  requests_sent = 0;
  int  results_seen = 0;
  int  clipped_seen = 0;
  int  settings_run = 0;
  bit  sender_idles = 1'b0;
  bit  receiver_stalls = 1'b0;
  int  stall_left = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit: a hang anywhere ends the run as a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d results outstanding at %0t",
               cycles, pending_results.size(), $time);
      $display("** interpolated_waveform_trap_force_core: FAILED **");
      $finish;
    end
  end

  // Gap length for either side: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // The receiver stalls in runs while stalls are enabled, and is otherwise
  // always ready. It changes only at the falling edge.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (receiver_stalls && $urandom_range(0, 99) < 30) begin
      stall_left = pick_gap();
      m_tready <= (stall_left == 0);
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Table entries in use: a count of zero acts as one, and anything beyond
  // the table depth is clamped to it.
  function automatic int eff_points();
    if (cfg_points == 0) return 1;
    if (cfg_points > TABLE_DEPTH_DEF) return TABLE_DEPTH_DEF;
    return int'(cfg_points);
  endfunction

  // Which two entries a phase interpolates between, and the 16-bit weight of
  // the upper one. The upper neighbour wraps to entry 0 at the end of the period.
  function automatic void slots_for(input logic [PHASE_W-1:0] ph, output int lo_slot,
                                    output int hi_slot, output int frac);
    logic [63:0] pos;
    int          n;
    n = eff_points();
    pos = 64'(ph) * 64'(n);
    lo_slot = int'(pos[63:32]);
    frac = int'(pos[31:16]);
    hi_slot = (lo_slot + 1 >= n) ? 0 : lo_slot + 1;
  endfunction

  // floor(pos * coef / 2^16), clamped to 32 bits; sat reports the clamp.
  function automatic logic signed [31:0] axis_force(input logic signed [31:0] pos,
                                                    input logic signed [35:0] coef,
                                                    output bit sat);
    logic signed [71:0] prod;
    logic signed [71:0] scaled;
    prod = pos * coef;
    scaled = prod >>> 16;
    sat = 1'b0;
    if (scaled > SAT_HI) begin
      sat = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (scaled < SAT_LO) begin
      sat = 1'b1;
      return 32'sh8000_0000;
    end
    return scaled[31:0];
  endfunction

  // Applies one accepted request to the mirror and queues the result it must produce.
  task automatic apply_request(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
    trap_result_t       r;
    int                 lo_slot;
    int                 hi_slot;
    int                 frac;
    longint             mix;
    logic signed [47:0] q_pot;
    logic signed [35:0] two_q_pot;
    logic signed [35:0] coef_x;
    logic signed [35:0] coef_y;
    logic signed [35:0] coef_z;
    bit                 sat_x;
    bit                 sat_y;
    bit                 sat_z;
    r.kind = op;
    r.fx = '0;
    r.fy = '0;
    r.fz = '0;
    r.clip = 1'b0;
    case (op)
      OP_LOAD: begin
        wave_mirror[d[9:0]] = d[25:10];
        entry_loaded[d[9:0]] = 1'b1;
      end
      OP_STEP: begin
        phase_acc = phase_acc + d[57:26];
        slots_for(phase_acc, lo_slot, hi_slot, frac);
        mix = longint'(wave_mirror[lo_slot]) * longint'(65536 - frac)
            + longint'(wave_mirror[hi_slot]) * longint'(frac);
        held_volt = 16'(mix >>> 16);
      end
      OP_FORCE: begin
        // 2*q*pot in Q16.16 is q * pot / 2^14, rounded toward minus infinity.
        q_pot = cfg_q * held_volt;
        two_q_pot = 36'(q_pot >>> 14);
        coef_x = two_q_pot - cfg_a;
        coef_y = -two_q_pot - cfg_a;
        coef_z = cfg_a;
        coef_z = coef_z + coef_z;
        r.fx = axis_force(d[89:58], coef_x, sat_x);
        r.fy = axis_force(d[121:90], coef_y, sat_y);
        r.fz = axis_force(d[153:122], coef_z, sat_z);
        r.clip = sat_x | sat_y | sat_z;
      end
      default: ;
    endcase
    r.volt = held_volt;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Every accepted result is checked against the oldest outstanding expectation.
  always @(posedge clk) begin
    trap_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser[2]) clipped_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got kind %0d data %h",
                 $time, m_tuser[1:0], m_tdata);
      end else begin
        want = pending_results.pop_front();
        report_field("result_kind", 32'(want.kind), 32'(m_tuser[1:0]));
        report_field("voltage_now", 32'(want.volt), 32'($signed(m_tdata[15:0])));
        report_field("force_x", want.fx, m_tdata[47:16]);
        report_field("force_y", want.fy, m_tdata[79:48]);
        report_field("force_z", want.fz, m_tdata[111:80]);
        report_field("clipped", 32'(want.clip), 32'(m_tuser[2]));
      end
    end
  end

  // Random bits for every field of a request; the caller overwrites the
  // fields that its opcode uses.
  function automatic logic [IN_DATA_W-1:0] noise_payload();
    logic [IN_DATA_W-1:0] d;
    d = {$urandom, $urandom, $urandom, $urandom, $urandom};
    d[IN_DATA_W-1:PAYLOAD_W] = '0;
    return d;
  endfunction

  // Presents one request after an optional gap and holds it until accepted.
  // Valid stays high after acceptance until the next falling edge, where it
  // either drops for a gap or carries the next request.
  task automatic send_request(input logic [1:0] op, input logic [IN_DATA_W-1:0] d);
    int gap;
    gap = sender_idles ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= d;
    s_tuser <= op;
    do @(posedge clk); while (!s_tready);
    apply_request(op, d);
    requests_sent++;
  endtask

  task automatic load_entry(input logic [LOAD_IDX_W-1:0] idx,
                            input logic [SAMPLE_W-1:0] value);
    logic [IN_DATA_W-1:0] d;
    d = noise_payload();
    d[9:0] = idx;
    d[25:10] = value;
    send_request(OP_LOAD, d);
  endtask

  // A step may only read entries that were loaded, so any missing neighbour
  // is loaded with a random sample first.
  task automatic step_time(input logic [PHASE_W-1:0] step);
    logic [IN_DATA_W-1:0] d;
    int lo_slot;
    int hi_slot;
    int frac;
    slots_for(phase_acc + step, lo_slot, hi_slot, frac);
    if (!entry_loaded[lo_slot]) load_entry(LOAD_IDX_W'(lo_slot), 16'($urandom));
    if (!entry_loaded[hi_slot]) load_entry(LOAD_IDX_W'(hi_slot), 16'($urandom));
    d = noise_payload();
    d[57:26] = step;
    send_request(OP_STEP, d);
  endtask

  task automatic force_query(input logic [31:0] px, input logic [31:0] py,
                             input logic [31:0] pz);
    logic [IN_DATA_W-1:0] d;
    d = noise_payload();
    d[89:58] = px;
    d[121:90] = py;
    d[153:122] = pz;
    send_request(OP_FORCE, d);
  endtask

  task automatic idle_request();
    send_request(OP_NOP, noise_payload());
  endtask

  // Drops valid and waits until every outstanding result has been taken,
  // then lets the block settle so that the register port sees it idle.
  task automatic wait_for_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register, reads it back, and updates the mirror.
  task automatic write_register(input reg_idx_t idx, input logic [REG_W-1:0] value);
    logic [REG_W-1:0] got;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(int'(idx) * 4);
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_POINT_COUNT: begin
        cfg_points = value[CNT_W-1:0];
        report_field("point_count readback", 32'(value[CNT_W-1:0]), 32'(got[CNT_W-1:0]));
      end
      REG_Q_COEF: begin
        cfg_q = value;
        report_field("q_coef readback", value, got);
      end
      default: begin
        cfg_a = value;
        report_field("a_coef readback", value, got);
      end
    endcase
  endtask

  task automatic configure(input logic [CNT_W-1:0] points, input logic [REG_W-1:0] q,
                           input logic [REG_W-1:0] a);
    wait_for_results();
    write_register(REG_POINT_COUNT, REG_W'(points));
    write_register(REG_Q_COEF, q);
    write_register(REG_A_COEF, a);
    settings_run++;
  endtask

  function automatic logic [31:0] small_signed(input int span);
    return 32'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  // Position: small, full range, or one of the two extremes.
  function automatic logic [31:0] pick_position();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return small_signed(1 << 20);
    if (r < 80) return $urandom;
    return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
  endfunction

  // Right after reset the potential and both coefficients are zero, so a
  // force query returns zero even at extreme positions; opcode 3 only echoes.
  task automatic test_reset_state();
    force_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    force_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    idle_request();
  endtask

  // Table edges: the first and last entries at the sample extremes, a step of
  // zero and a step of all ones, which lands in the last entry and wraps its
  // upper neighbour to entry 0, then a step between entries 512 and 513.
  task automatic test_table_edges();
    load_entry(10'd0, 16'h7FFF);
    load_entry(10'd1023, 16'h8000);
    step_time(32'h0000_0000);
    step_time(32'hFFFF_FFFF);
    idle_request();
    load_entry(10'd512, 16'h8000);
    load_entry(10'd513, 16'h7FFF);
    step_time(32'h8000_8001);
  endtask

  // Coefficient extremes drive every axis into saturation; a modest setting
  // afterwards checks the products without clamping.
  task automatic test_force_extremes();
    configure(11'd1024, 32'h7FFF_FFFF, 32'h8000_0000);
    force_query(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    force_query(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000);
    configure(11'd1024, 32'h8000_0000, 32'h7FFF_FFFF);
    force_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    configure(11'd1024, 32'h0001_0000, 32'hFFFF_8000);
    force_query(32'h0003_0000, 32'hFFFD_0000, 32'h0000_4000);
  endtask

  // A point count of zero behaves as one, counts past the table depth clamp
  // to it, and a count of one interpolates entry 0 with itself.
  task automatic test_point_count_edges();
    configure(11'd0, 32'h0000_4000, 32'h0000_1000);
    step_time(32'h4000_0000);
    force_query(32'h0010_0000, 32'h0010_0000, 32'h0010_0000);
    configure(11'd2047, 32'h0000_4000, 32'h0000_1000);
    step_time(32'h1234_5678);
    configure(11'd1, 32'h0000_4000, 32'h0000_1000);
    step_time(32'h7FFF_FFFF);
  endtask

  // One random setting: a stream that mixes loads, steps, force queries and
  // the spare opcode. With pause set, the sender waits halfway through until
  // every result has arrived.
  task automatic test_random_setting(input logic [CNT_W-1:0] points,
                                     input logic [REG_W-1:0] q, input logic [REG_W-1:0] a,
                                     input bit idles, input bit pause);
    int   r;
    int   n;
    logic [SAMPLE_W-1:0] value;
    logic [PHASE_W-1:0]  step;
    configure(points, q, a);
    sender_idles = idles;
    receiver_stalls = idles;
    n = eff_points();
    for (int k = 0; k < REQUESTS_PER_SETTING; k++) begin
      if (pause && k == REQUESTS_PER_SETTING / 2) wait_for_results();
      r = $urandom_range(0, 99);
      if (r < 30) begin
        value = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 16'h7FFF : 16'h8000)
                                             : 16'($urandom);
        if ($urandom_range(0, 9) < 7) load_entry(LOAD_IDX_W'($urandom_range(0, n - 1)), value);
        else load_entry(LOAD_IDX_W'($urandom), value);
      end else if (r < 60) begin
        r = $urandom_range(0, 9);
        if (r < 5) step = $urandom;
        else if (r < 9) step = $urandom_range(0, 1 << 26);
        else step = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        step_time(step);
      end else if (r < 95) begin
        force_query(pick_position(), pick_position(), pick_position());
      end else begin
        idle_request();
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sender_idles = 1'b1;
    receiver_stalls = 1'b1;
    test_reset_state();
    test_table_edges();
    test_force_extremes();
    test_point_count_edges();

    // Mostly small coefficients so the products stay in range, with the
    // register extremes and full-range values in between.
    test_random_setting(11'd1024, small_signed(1 << 18), small_signed(1 << 18), 1'b1, 1'b0);
    test_random_setting(11'd1, small_signed(1 << 18), small_signed(1 << 18), 1'b0, 1'b0);
    test_random_setting(11'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 1'b0);
    test_random_setting(11'd2047, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 1'b0);
    test_random_setting(11'($urandom_range(2, 16)), $urandom, $urandom, 1'b1, 1'b0);
    test_random_setting(11'd1025, small_signed(1 << 18), small_signed(1 << 18), 1'b1, 1'b1);
    test_random_setting(11'($urandom_range(1, 1024)), small_signed(1 << 18),
                        small_signed(1 << 18), 1'b0, 1'b0);
    test_random_setting(11'd2, 32'h0000_0000, small_signed(1 << 16), 1'b1, 1'b0);

    wait_for_results();
    $display("Ran %0d requests over %0d register settings plus reset defaults.",
             requests_sent, settings_run);
    $display("Checked %0d results, %0d of them with a clamped force, %0d errors.",
             results_seen, clipped_seen, errors);
    if (errors == 0) begin
      $display("** interpolated_waveform_trap_force_core: PASSED **");
    end else begin
      $display("** interpolated_waveform_trap_force_core: FAILED **");
    end
    $finish;
  end

endmodule

`default_nettype wire
